// ----- src/cbd_pkg.sv -----
`timescale 1ns / 1ps
package cbd_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CAP_W      = 5;

  localparam logic [WORD_WIDTH-1:0] MOST_NEG_WORD = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic [CAP_W-1:0]      CAP_RESET     = CAP_W'(16);
  localparam logic [CAP_W-1:0]      CAP_MAX       = CAP_W'(DEPTH);

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

endpackage

// ----- src/cbd_if.sv -----
`timescale 1ns / 1ps
interface cbd_req_if;
  import cbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [2:0]            op;
  logic [WORD_WIDTH-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cbd_rsp_if;
  import cbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] read_value;
  logic [1:0]            status;
  logic                  is_empty_now;
  logic                  is_full_now;

  modport source (output valid, output read_value, output status, output is_empty_now,
                  output is_full_now, input ready);
  modport sink   (input valid, input read_value, input status, input is_empty_now,
                  input is_full_now, output ready);
endinterface

// ----- src/cbd_ram.sv -----
`timescale 1ns / 1ps
module cbd_ram
  import cbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [IDX_W-1:0]      addr,
  input  logic [WORD_WIDTH-1:0] wdata,
  output logic [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/circular_buffer_deque.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake     word
// req      in   valid/ready   op, push_value
// rsp      out  valid/ready   read_value, status, is_empty_now, is_full_now
// cfg      in   cfg_we        cfg_wdata = capacity_in_use
//
// a request: indices update and the store is read or written in the accept
// cycle, then the store's registered read data lands in the result register
// once that register is free; req is not ready for a new request until then.
// rst (synchronous) empties the deque and sets the capacity to 16; the store
// itself is not cleared. a result held by a stalled rsp does not block the
// next request, only the one after it waits.
module circular_buffer_deque
  import cbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  cbd_req_if.sink          req,
  cbd_rsp_if.source        rsp
);

  state_t state, state_next;

  logic [CAP_W-1:0] cap;
  logic [IDX_W-1:0] front, rear;
  logic             empty;

  logic [CAP_W-1:0] cap_eff;
  logic [IDX_W-1:0] cap_m1;

  logic [IDX_W-1:0] front_next, rear_next;
  logic             empty_next;
  logic [1:0]       status_new;
  logic             use_mem_new;
  logic             full_now, full_after;

  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_addr;
  logic [WORD_WIDTH-1:0] mem_rdata;

  logic [1:0] pend_status;
  logic       pend_use_mem, pend_empty, pend_full;

  logic accept, rsp_load;
  op_t  op;

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] i, logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] n;
    n = {{(CAP_W-IDX_W){1'b0}}, i} + CAP_W'(1);
    return (n >= c) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(logic [IDX_W-1:0] i, logic [IDX_W-1:0] cm1);
    return (i == '0) ? cm1 : i - IDX_W'(1);
  endfunction

  assign op      = op_t'(req.op);
  assign accept  = req.valid && req.ready;
  assign cap_eff = (cap == '0) ? CAP_W'(1) : ((cap > CAP_MAX) ? CAP_MAX : cap);
  assign cap_m1  = IDX_W'(cap_eff - CAP_W'(1));
  assign full_now = !empty && (wrap_inc(rear, cap_eff) == front);

  always_comb begin
    front_next  = front;
    rear_next   = rear;
    empty_next  = empty;
    status_new  = STATUS_DONE;
    use_mem_new = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = front;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full_now) begin
          status_new = STATUS_FULL;
        end else begin
          mem_we = accept;
          if (empty) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b0;
            mem_addr   = '0;
          end else if (op == OP_PUSH_FRONT) begin
            front_next = wrap_dec(front, cap_m1);
            mem_addr   = front_next;
          end else begin
            rear_next = wrap_inc(rear, cap_eff);
            mem_addr  = rear_next;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (empty) begin
          status_new = STATUS_EMPTY;
        end else begin
          mem_re      = accept;
          use_mem_new = 1'b1;
          mem_addr    = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ? front : rear;
          if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
            if (front == rear) begin
              front_next = '0;
              rear_next  = '0;
              empty_next = 1'b1;
            end else if (op == OP_POP_FRONT) begin
              front_next = wrap_inc(front, cap_eff);
            end else begin
              rear_next = wrap_dec(rear, cap_m1);
            end
          end
        end
      end
      default: begin
        // undefined codes change nothing
      end
    endcase
  end

  assign full_after = !empty_next && (wrap_inc(rear_next, cap_eff) == front_next);

  cbd_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (req.push_value),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_RESET;
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
    end else if (cfg_we) begin
      cap   <= cfg_wdata;
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
    end else if (accept) begin
      front <= front_next;
      rear  <= rear_next;
      empty <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status  <= status_new;
      pend_use_mem <= use_mem_new;
      pend_empty   <= empty_next;
      pend_full    <= full_after;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_BUSY;
      ST_BUSY: if (rsp_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    rsp_load  = (state == ST_BUSY) && (!rsp.valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.read_value   <= pend_use_mem ? mem_rdata : MOST_NEG_WORD;
      rsp.status       <= pend_status;
      rsp.is_empty_now <= pend_empty;
      rsp.is_full_now  <= pend_full;
    end
  end

  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    empty |-> (front == '0 && rear == '0))
    else $error("empty deque with nonzero index");

  a_idx_cap: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, front} < cap_eff) && ({1'b0, rear} < cap_eff))
    else $error("index beyond capacity");

  a_rw_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store read and write in one cycle");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_we && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)) |=> !empty)
    else $error("deque empty after a push");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import cbd_pkg::*;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam logic [WORD_WIDTH-1:0] MOST_POS_WORD = ~MOST_NEG_WORD;
  localparam int LONG_HOLD    = 80;
  localparam int PHASE_ITEMS  = 120;
  localparam int PHASE_COUNT  = 10;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] read_value;
    logic [1:0]            status;
    logic                  is_empty_now;
    logic                  is_full_now;
  } deque_reply_t;

  class deque_tracker;
    bit [WORD_WIDTH-1:0] slots [DEPTH];
    bit [IDX_W-1:0]      head;
    bit [IDX_W-1:0]      tail;
    bit                  empty_state = 1'b1;
    bit [CAP_W-1:0]      cap_setting = CAP_RESET;
    deque_reply_t        expected_replies [$];
    int                  mismatches;

    function int unsigned usable_capacity();
      if (cap_setting == 0) return 1;
      if (cap_setting > CAP_MAX) return DEPTH;
      return cap_setting;
    endfunction

    function bit [IDX_W-1:0] index_after(bit [IDX_W-1:0] i);
      int unsigned n;
      n = i + 1;
      return (n >= usable_capacity()) ? '0 : IDX_W'(n);
    endfunction

    function bit [IDX_W-1:0] index_before(bit [IDX_W-1:0] i);
      return (i == 0) ? IDX_W'(usable_capacity() - 1) : i - 1'b1;
    endfunction

    function bit deque_full();
      return !empty_state && index_after(tail) == head;
    endfunction

    // a capacity write also empties the deque
    function void write_capacity(bit [CAP_W-1:0] value);
      cap_setting = value;
      head = '0;
      tail = '0;
      empty_state = 1'b1;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(logic [2:0] op, logic [WORD_WIDTH-1:0] value);
      deque_reply_t   r;
      bit [IDX_W-1:0] slot;
      bit             at_front;
      r.read_value = MOST_NEG_WORD;
      r.status     = STATUS_DONE;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (deque_full()) begin
            r.status = STATUS_FULL;
          end else begin
            if (empty_state) begin
              head = '0;
              tail = '0;
              empty_state = 1'b0;
              slot = '0;
            end else if (op == OP_PUSH_FRONT) begin
              head = index_before(head);
              slot = head;
            end else begin
              tail = index_after(tail);
              slot = tail;
            end
            slots[slot] = value;
          end
        end
        OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
          if (empty_state) begin
            r.status = STATUS_EMPTY;
          end else begin
            at_front = (op == OP_POP_FRONT) || (op == OP_PEEK_FRONT);
            slot = at_front ? head : tail;
            r.read_value = slots[slot];
            if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
              if (head == tail) begin
                head = '0;
                tail = '0;
                empty_state = 1'b1;
              end else if (at_front) begin
                head = index_after(head);
              end else begin
                tail = index_before(tail);
              end
            end
          end
        end
        default: ;
      endcase
      r.is_empty_now = empty_state;
      r.is_full_now  = deque_full();
      expected_replies.push_back(r);
    endfunction

    function void check_reply(deque_reply_t got);
      deque_reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply: value %h status %0d empty %b full %b",
                   got.read_value, got.status, got.is_empty_now, got.is_full_now);
        return;
      end
      want = expected_replies[0];
      expected_replies.delete(0);
      if (got.read_value !== want.read_value || got.status !== want.status ||
          got.is_empty_now !== want.is_empty_now || got.is_full_now !== want.is_full_now) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("reply mismatch: want %h/%0d/%b/%b got %h/%0d/%b/%b (value/status/empty/full)",
                   want.read_value, want.status, want.is_empty_now, want.is_full_now,
                   got.read_value, got.status, got.is_empty_now, got.is_full_now);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  cbd_req_if req_ch ();
  cbd_rsp_if rsp_ch ();

  circular_buffer_deque dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  deque_tracker tracker = new();
  bit idle_on;
  bit hold_request;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [WORD_WIDTH-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return MOST_NEG_WORD;
    if (r < 16) return MOST_POS_WORD;
    if (r < 20) return '0;
    if (r < 24) return '1;
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_op(int push_pct);
    if ($urandom_range(0, 99) < 3)
      return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    case ($urandom_range(0, 5))
      0, 1:    return OP_POP_FRONT;
      2, 3:    return OP_POP_REAR;
      4:       return OP_PEEK_FRONT;
      default: return OP_PEEK_REAR;
    endcase
  endfunction

  task automatic send_request(input logic [2:0] op, input logic [WORD_WIDTH-1:0] value);
    int gap;
    gap = idle_on ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk) req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.push_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(op, value);
  endtask

  task automatic drain_replies();
    @(negedge clk) req_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_replies();
    // let the result register settle before touching the deque
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk) tracker.write_capacity(value);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input bit calm, input bit hold);
    int push_pct;
    set_capacity(cap);
    idle_on = !calm;
    if (hold) hold_request = 1'b1;
    push_pct = 75;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // swing between filling and draining so both full and empty are reached
      if (i % 24 == 0) push_pct = (push_pct > 50) ? 25 : 75;
      send_request(pick_op(push_pct), pick_word());
    end
  endtask

  always @(posedge clk) begin : watch_replies
    deque_reply_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.read_value   = rsp_ch.read_value;
      got.status       = rsp_ch.status;
      got.is_empty_now = rsp_ch.is_empty_now;
      got.is_full_now  = rsp_ch.is_full_now;
      tracker.check_reply(got);
    end
  end

  initial begin : reply_sink
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // long hold-off while the sender keeps offering words
        rsp_ch.ready <= 1'b0;
        for (int held = 0; held < LONG_HOLD; held++) @(negedge clk);
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        stall = idle_length() + 1;
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [PHASE_COUNT];
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_PUSH_FRONT;
    req_ch.push_value = '0;
    idle_on           = 1'b0;
    hold_request      = 1'b0;
    phase_caps = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd3, 5'd16, 5'd7, 5'd4, 5'd12};
    phase_caps[8] = CAP_W'($urandom_range(1, 16));
    phase_caps[9] = CAP_W'($urandom_range(1, 31));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity: empty accesses, unused ops, both ends, last pop
    send_request(OP_PEEK_FRONT, '0);
    send_request(OP_POP_REAR, '0);
    send_request(OP_PEEK_REAR, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_UNUSED_6, MOST_POS_WORD);
    send_request(OP_PUSH_FRONT, MOST_NEG_WORD);
    send_request(OP_PUSH_REAR, MOST_POS_WORD);
    send_request(OP_PUSH_FRONT, '0);
    send_request(OP_PEEK_FRONT, '1);
    send_request(OP_PEEK_REAR, '0);
    send_request(OP_UNUSED_7, '1);
    send_request(OP_POP_REAR, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_FRONT, '0);

    // two entries: refused pushes when full
    set_capacity(5'd2);
    send_request(OP_PUSH_REAR, '1);
    send_request(OP_PUSH_REAR, 32'h5a5a_a5a5);
    send_request(OP_PUSH_FRONT, 32'h1234_5678);
    send_request(OP_PUSH_REAR, MOST_NEG_WORD);
    send_request(OP_PEEK_REAR, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_REAR, '0);
    send_request(OP_POP_REAR, '0);

    for (int p = 0; p < PHASE_COUNT; p++)
      run_phase(phase_caps[p], p == 0 || p == 3 || p == 5, p == 3);

    idle_on = 1'b0;
    drain_replies();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ----- circular_buffer_deque.f -----
src/cbd_pkg.sv
src/cbd_if.sv
src/cbd_ram.sv
src/circular_buffer_deque.sv
test/tb_top.sv
